[rtl/pcs_pkg.sv]
// shared types and constants for the completion splitter
package pcs_pkg;

  localparam int unsigned MAX_PAYLOAD_DEFAULT = 256;
  localparam int unsigned MAX_RESULTS         = 16;
  localparam int unsigned RES_CNT_W           = $clog2(MAX_RESULTS);
  localparam int unsigned QUEUE_DEPTH         = 2;
  localparam int unsigned BYTES_W             = 13;
  localparam int unsigned IN_DATA_W           = 112;
  localparam int unsigned OUT_DATA_W          = 104;
  localparam logic [10:0] LEN_MAX_DWORDS      = 11'd1024;

  typedef enum logic [1:0] {
    KIND_CPLD     = 2'd0,
    KIND_ABORT    = 2'd1,
    KIND_WRITE_OK = 2'd2
  } kind_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    kind_t               kind;
    logic [BYTES_W-1:0]  len_bytes;
    logic [BYTES_W-1:0]  byte_count;
    logic [6:0]          low_addr;
    logic [31:0]         offset;
    logic [7:0]          tag;
    logic [15:0]         requester;
  } req_entry_t;

endpackage

[rtl/pcs_front.sv]
// request intake and window range check
module pcs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pcs_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic [63:0]                   window_base,
  input  logic [31:0]                   window_size,
  output logic                          push_valid,
  output pcs_pkg::req_entry_t           push_entry,
  input  logic                          full
);
  import pcs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_CMP, ST_PUSH} state_t;

  state_t             state;
  logic               cmd;
  logic [63:0]        addr;
  logic [BYTES_W-1:0] span;
  logic [BYTES_W-1:0] bc;
  logic [7:0]         tag;
  logic [15:0]        req;
  logic [64:0]        end_sum;
  logic [64:0]        limit;
  logic               ge_base;
  logic [31:0]        offset;
  logic               in_range;

  logic [10:0]        in_ldw;
  logic [10:0]        eff_ldw;
  logic [BYTES_W-1:0] in_bc;

  assign in_ldw  = s_tdata[74:64];
  assign in_bc   = s_tdata[87:75];
  // zero or oversized length means the full 1024 dwords
  assign eff_ldw = (in_ldw == '0 || in_ldw > LEN_MAX_DWORDS) ? LEN_MAX_DWORDS : in_ldw;

  assign s_tready   = (state == ST_IDLE);
  assign push_valid = (state == ST_PUSH) && !full;

  always_comb begin
    push_entry.tag        = tag;
    push_entry.requester  = req;
    push_entry.len_bytes  = span;
    push_entry.byte_count = bc;
    push_entry.low_addr   = addr[6:0];
    push_entry.offset     = offset;
    if (!in_range) begin
      push_entry.kind       = KIND_ABORT;
      push_entry.len_bytes  = '0;
      push_entry.byte_count = '0;
      push_entry.low_addr   = '0;
      push_entry.offset     = '0;
    end else if (cmd) begin
      push_entry.kind = KIND_WRITE_OK;
    end else begin
      push_entry.kind = KIND_CPLD;
    end
  end

  always_ff @(posedge clk) begin
    // window end, refreshed every cycle from the config registers
    limit <= {1'b0, window_base} + {33'b0, window_size};
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tuser;
            addr  <= s_tdata[63:0];
            bc    <= in_bc;
            tag   <= s_tdata[95:88];
            req   <= s_tdata[111:96];
            span  <= s_tuser ? in_bc : {eff_ldw, 2'b00};
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          end_sum <= {1'b0, addr} + {52'b0, span};
          ge_base <= (addr >= window_base);
          offset  <= {addr[31:2], 2'b00} - window_base[31:0];
          state   <= ST_CMP;
        end
        ST_CMP: begin
          in_range <= !end_sum[64] && !limit[64] && ge_base && (end_sum[63:0] <= limit[63:0]);
          state    <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/pcs_queue.sv]
// short queue of classified requests between front and back end
module pcs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  pcs_pkg::req_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                pop_valid,
  output pcs_pkg::req_entry_t pop_entry
);
  import pcs_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  req_entry_t      slots [QUEUE_DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rp];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots[wp] <= push_entry;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push_valid) begin
        wp <= (wp == AW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push_valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push_valid) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/pcs_back.sv]
// completion sequencer and output register
module pcs_back #(
  parameter int unsigned MAX_PAYLOAD_BYTES = pcs_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  pcs_pkg::req_entry_t            q_entry,
  output logic                           q_pop,
  input  logic [15:0]                    completer_id,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pcs_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast
);
  import pcs_pkg::*;

  localparam logic [BYTES_W-1:0] MPB    = BYTES_W'(MAX_PAYLOAD_BYTES);
  localparam int unsigned        DLEN_W = BYTES_W + 2;

  logic                 busy;
  kind_t                kind;
  logic [BYTES_W-1:0]   len;
  logic [DLEN_W-1:0]    dlen;
  logic [6:0]           low;
  logic [31:0]          off;
  logic [7:0]           tag;
  logic [15:0]          req;
  logic [RES_CNT_W-1:0] res_cnt;

  logic                 emit;
  logic                 done;
  logic [BYTES_W-1:0]   chunk;
  logic [BYTES_W-1:0]   len_next;
  logic [DLEN_W-1:0]    dlen_next;
  logic [6:0]           low_next;
  logic [31:0]          off_next;
  logic [6:0]           chunk_dw;

  assign q_pop = !busy && q_valid;
  assign emit  = busy && (!m_tvalid || m_tready);

  always_comb begin
    chunk     = (len < MPB) ? len : MPB;
    len_next  = len - chunk;
    // byte count shrinks by the chunk less the first-byte offset
    dlen_next = dlen - DLEN_W'(chunk) + DLEN_W'(low[1:0]);
    low_next  = {low[6:2], 2'b00} + chunk[6:0];
    // offset follows the dword-aligned running address
    off_next  = off + 32'({chunk[BYTES_W-1:2], 2'b00});
    chunk_dw  = (kind == KIND_CPLD) ? chunk[8:2] : '0;
    done      = (kind != KIND_CPLD) || dlen_next[DLEN_W-1] || (dlen_next == '0) ||
                (len_next == '0) || (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy    <= 1'b1;
        kind    <= q_entry.kind;
        len     <= q_entry.len_bytes;
        dlen    <= {2'b00, q_entry.byte_count};
        low     <= q_entry.low_addr;
        off     <= q_entry.offset;
        tag     <= q_entry.tag;
        req     <= q_entry.requester;
        res_cnt <= '0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'b0, off, completer_id, req, tag, low, dlen[BYTES_W-1:0], chunk_dw};
        m_tuser  <= kind;
        m_tlast  <= done;
        len      <= len_next;
        dlen     <= dlen_next;
        low      <= low_next;
        off      <= off_next;
        res_cnt  <= res_cnt + 1'b1;
        if (done) begin
          busy <= 1'b0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/pcie_completion_splitter_top.sv]
// top level of the read completion splitter with its config registers
//
// Completer side of a memory window behind PCIe memory requests. Each
// transfer on the slave stream is one request; reads that fall inside the
// configured window turn into a run of completion headers of at most
// MAX_PAYLOAD_BYTES each (at most 16, the last one flagged by tlast),
// writes turn into one accept result, and anything outside the window,
// including requests whose end address or window end overflows 64 bits,
// turns into one abort result. The front end takes one request at a time
// and steps it through capture, end-address sum, limit compare and queue
// push, the push waiting while the queue is full; it takes no new request
// until that push is done. The back end loads a request from the two-entry
// queue and then gives one result per cycle while the master side is ready;
// it loads the next request only after issuing the last result of this one.
// Config registers may only be written while no request is in flight.
module pcie_completion_splitter_top #(
  parameter int unsigned MAX_PAYLOAD_BYTES = pcs_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [63:0] address, [74:64] length_dwords, [87:75] byte_count,
  // [95:88] tag, [111:96] requester_id
  input  logic [pcs_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] command: 0 memory read, 1 memory write
  input  logic                           s_tuser,
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [6:0] chunk_dwords, [19:7] bytes_remaining, [26:20] lower_address,
  // [34:27] out_tag, [50:35] out_requester, [66:51] out_completer,
  // [98:67] window_offset, [103:99] zero
  output logic [pcs_pkg::OUT_DATA_W-1:0] m_tdata,
  // [1:0] kind: 0 completion with data, 1 abort, 2 write accepted
  output logic [1:0]                     m_tuser,
  // last result of the request
  output logic                           m_tlast,
  // config write port
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [63:0]                    cfg_data
);
  import pcs_pkg::*;

  localparam logic [1:0]  CFG_WINDOW_BASE    = 2'd0;
  localparam logic [1:0]  CFG_WINDOW_SIZE    = 2'd1;
  localparam logic [1:0]  CFG_COMPLETER_ID   = 2'd2;
  localparam logic [31:0] WINDOW_SIZE_RESET  = 32'h1000_0000;

  logic [63:0] window_base;
  logic [31:0] window_size;
  logic [15:0] completer_id;

  logic        push_valid;
  req_entry_t  push_entry;
  logic        q_full;
  logic        q_pop;
  logic        q_valid;
  req_entry_t  q_entry;

  // config registers, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= '0;
      window_size  <= WINDOW_SIZE_RESET;
      completer_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_BASE:  window_base  <= cfg_data;
        CFG_WINDOW_SIZE:  window_size  <= cfg_data[31:0];
        CFG_COMPLETER_ID: completer_id <= cfg_data[15:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // intake and range check
  pcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .window_base (window_base),
    .window_size (window_size),
    .push_valid  (push_valid),
    .push_entry  (push_entry),
    .full        (q_full)
  );

  // decouples intake from result generation
  pcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry)
  );

  // splits reads into completions and drives the output register
  pcs_back #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .completer_id (completer_id),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

endmodule

[tb/tb.sv]
// self-checking testbench for the pcie completion splitter
`timescale 1ns / 1ps

module tb;
  import pcs_pkg::*;

  // request commands carried on s_tuser
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // config register indexes
  localparam logic [1:0] REG_WINDOW_BASE  = 2'd0;
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd1;
  localparam logic [1:0] REG_COMPLETER_ID = 2'd2;

  localparam int MAX_PAYLOAD  = MAX_PAYLOAD_DEFAULT;
  localparam int DRAIN_CYCLES = 24;   // front end plus back end load, with margin

  // one completion header or status as it leaves the block
  typedef struct {
    kind_t       kind;
    logic [6:0]  chunk_dw;
    logic [12:0] bytes_left;
    logic [6:0]  low_addr;
    logic [7:0]  tag;
    logic [15:0] requester;
    logic [15:0] completer;
    logic [31:0] offset;
    logic        is_last;
  } cpl_header_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [63:0]           cfg_data;

  // shadow of the config registers as the block should hold them
  logic [63:0] win_base;
  logic [31:0] win_size;
  logic [15:0] cpl_id;

  cpl_header_t cpl_expected[$];

  int  mismatches;
  int  n_reads, n_writes, n_aborts, n_headers, n_settings;
  bit  idle_off;     // set for back-to-back stretches on both sides
  int  ready_hold;

  pcie_completion_splitter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // safety net: far beyond the slowest correct run
  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // window check with 64-bit overflow of either sum counting as a miss
  function automatic bit window_hit(logic [63:0] addr, logic [63:0] span);
    logic [64:0] end_sum;
    logic [64:0] lim_sum;
    end_sum = {1'b0, addr} + {1'b0, span};
    lim_sum = {1'b0, win_base} + {33'b0, win_size};
    if (end_sum[64] || lim_sum[64]) return 1'b0;
    return (addr >= win_base) && (end_sum[63:0] <= lim_sum[63:0]);
  endfunction

  // work out every header a request should produce and queue them in order
  task automatic split_request(input logic cmd, input logic [63:0] addr,
                               input logic [10:0] ldw, input logic [12:0] bc,
                               input logic [7:0] tag, input logic [15:0] rid);
    cpl_header_t h;
    logic [63:0] run_addr;
    logic [63:0] aligned;
    int          len;
    int          chunk;
    int          left;
    int          n;
    bit          done;
    h.tag        = tag;
    h.requester  = rid;
    h.completer  = cpl_id;
    h.kind       = KIND_ABORT;
    h.chunk_dw   = '0;
    h.bytes_left = '0;
    h.low_addr   = '0;
    h.offset     = '0;
    h.is_last    = 1'b1;
    if (cmd == CMD_WRITE) begin
      n_writes++;
      if (window_hit(addr, {51'b0, bc})) begin
        h.kind       = KIND_WRITE_OK;
        h.bytes_left = bc;
        h.low_addr   = addr[6:0];
        h.offset     = 32'({addr[63:2], 2'b00} - win_base);
      end else begin
        n_aborts++;
      end
      cpl_expected.push_back(h);
      return;
    end
    n_reads++;
    // zero and oversized lengths both mean the full 1024 dwords
    len = (ldw == 11'd0 || ldw > LEN_MAX_DWORDS) ? 4096 : int'(ldw) * 4;
    if (!window_hit(addr, 64'(len))) begin
      n_aborts++;
      cpl_expected.push_back(h);
      return;
    end
    h.kind   = KIND_CPLD;
    left     = int'(bc);
    run_addr = addr;
    n        = 0;
    done     = 1'b0;
    while (!done) begin
      chunk        = (len < MAX_PAYLOAD) ? len : MAX_PAYLOAD;
      aligned      = {run_addr[63:2], 2'b00};
      h.chunk_dw   = 7'(chunk >> 2);
      h.bytes_left = 13'(left);
      h.low_addr   = run_addr[6:0];
      h.offset     = 32'(aligned - win_base);
      n++;
      len  -= chunk;
      // only the first chunk can start off a dword boundary
      left -= chunk - int'(run_addr[1:0]);
      run_addr = aligned + 64'(chunk);
      done = (left <= 0) || (len == 0) || (n >= MAX_RESULTS);
      h.is_last = done;
      cpl_expected.push_back(h);
    end
  endtask

  // one request transfer; valid is left high so back-to-back requests
  // never see a low-high pair in one time step
  task automatic send_request(input logic cmd, input logic [63:0] addr,
                              input logic [10:0] ldw, input logic [12:0] bc,
                              input logic [7:0] tag, input logic [15:0] rid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {rid, tag, bc, ldw, addr};
    do @(posedge clk); while (!s_tready);
    split_request(cmd, addr, ldw, bc, tag, rid);
  endtask

  // drop valid, wait out every header, then the pipeline tail
  task automatic drain();
    s_tvalid <= 1'b0;
    while (cpl_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // single-cycle register write, only ever called with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_BASE:  win_base = value;
      REG_WINDOW_SIZE:  win_size = value[31:0];
      REG_COMPLETER_ID: cpl_id   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [63:0] base, input logic [31:0] size,
                            input logic [15:0] id);
    write_reg(REG_WINDOW_BASE, base);
    write_reg(REG_WINDOW_SIZE, {32'b0, size});
    write_reg(REG_COMPLETER_ID, {48'b0, id});
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  // result side: every transfer is matched against the oldest prediction
  always @(posedge clk) begin
    cpl_header_t h;
    if (!rst && m_tvalid && m_tready) begin
      if (cpl_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got kind %0d tdata 0x%0h",
                 $time, m_tuser, m_tdata);
      end else begin
        h = cpl_expected.pop_front();
        n_headers++;
        check_field("kind",            h.kind,       m_tuser);
        check_field("chunk_dwords",    h.chunk_dw,   m_tdata[6:0]);
        check_field("bytes_remaining", h.bytes_left, m_tdata[19:7]);
        check_field("lower_address",   h.low_addr,   m_tdata[26:20]);
        check_field("out_tag",         h.tag,        m_tdata[34:27]);
        check_field("out_requester",   h.requester,  m_tdata[50:35]);
        check_field("out_completer",   h.completer,  m_tdata[66:51]);
        check_field("window_offset",   h.offset,     m_tdata[98:67]);
        check_field("last",            h.is_last,    m_tlast);
      end
    end
  end

  // master-side back-pressure: random stalls unless a stretch turns them off
  initial begin
    m_tready   = 1'b0;
    ready_hold = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
        m_tready <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 3) == 0) begin
        ready_hold = pick_gap();
        if (ready_hold > 0) ready_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // default window straight out of reset, plus the length and count corners
  task automatic test_reset_window();
    send_request(CMD_READ,  64'h0,         11'd1,    13'd4,    8'h00, 16'h0000);
    send_request(CMD_READ,  64'h3,         11'd2,    13'd5,    8'h01, 16'h0001);
    // zero length means 1024 dwords, sixteen max-payload chunks
    send_request(CMD_READ,  64'h100,       11'd0,    13'd4096, 8'h02, 16'h1234);
    // length above 1024 saturates
    send_request(CMD_READ,  64'h1002,      11'd2047, 13'd4094, 8'h03, 16'h8000);
    // read with a zero byte count still gives one header
    send_request(CMD_READ,  64'h40,        11'd4,    13'd0,    8'h04, 16'h00ff);
    // byte count running past the length ends on the length
    send_request(CMD_READ,  64'h7e,        11'd4,    13'd8191, 8'hff, 16'hffff);
    send_request(CMD_READ,  64'h7e,        11'd64,   13'd250,  8'h5a, 16'ha5a5);
    // full 4 KiB ending exactly at the window end, then one dword past it
    send_request(CMD_READ,  64'h0FFF_F000, 11'd1024, 13'd4096, 8'h06, 16'h0006);
    send_request(CMD_READ,  64'h0FFF_F004, 11'd1024, 13'd4096, 8'h07, 16'h0007);
    send_request(CMD_WRITE, 64'h0FFF_FFFF, 11'd1,    13'd1,    8'h08, 16'h0008);
    send_request(CMD_WRITE, 64'h0FFF_FFFF, 11'd1,    13'd2,    8'h09, 16'h0009);
    send_request(CMD_WRITE, 64'h123,       11'd0,    13'd0,    8'h0a, 16'h000a);
    send_request(CMD_WRITE, 64'h2001,      11'd2047, 13'd8191, 8'h0b, 16'h000b);
    // end address wraps past 2^64
    send_request(CMD_READ,  64'hFFFF_FFFF_FFFF_FFFF, 11'd1, 13'd4, 8'h0c, 16'h000c);
    send_request(CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFE, 11'd1, 13'd4, 8'h0d, 16'h000d);
    drain();
  endtask

  // extreme window settings: limit overflow, top of the address space, empty
  task automatic test_window_edges();
    set_window(64'hFFFF_FFFF_FFFF_0000, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_READ,  64'hFFFF_FFFF_FFFF_0000, 11'd1, 13'd4, 8'h10, 16'h0010);
    send_request(CMD_WRITE, 64'hFFFF_FFFF_FFFF_0000, 11'd1, 13'd0, 8'h11, 16'h0011);
    drain();
    set_window(64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 16'h8001);
    send_request(CMD_READ,  64'hFFFF_FFFF_FFFF_FFF1, 11'd3, 13'd11, 8'h12, 16'h0012);
    send_request(CMD_READ,  64'hFFFF_FFFE_FFFF_FFFC, 11'd1, 13'd4,  8'h13, 16'h0013);
    send_request(CMD_WRITE, 64'hFFFF_FFFF_FFFF_FFFB, 11'd1, 13'd4,  8'h14, 16'h0014);
    drain();
    set_window(64'h0, 32'h0, 16'h0000);
    send_request(CMD_READ,  64'h0, 11'd1, 13'd4, 8'h15, 16'h0015);
    send_request(CMD_WRITE, 64'h0, 11'd1, 13'd0, 8'h16, 16'h0016);
    drain();
  endtask

  // mostly well-formed requests aimed into the current window
  task automatic send_random_request();
    logic        cmd;
    logic [63:0] addr;
    logic [10:0] ldw;
    logic [12:0] bc;
    int          r;
    int          span;
    r = $urandom_range(0, 99);
    if (r < 70)
      addr = win_base + (64'($urandom) % (64'(win_size) + 64'd1));
    else if (r < 85)
      addr = win_base + 64'(win_size) - 64'($urandom_range(0, 600));
    else
      addr = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 70)      ldw = 11'($urandom_range(1, 64));
    else if (r < 85) ldw = 11'($urandom_range(65, 1024));
    else if (r < 90) ldw = 11'd1024;
    else if (r < 95) ldw = 11'd0;
    else             ldw = 11'($urandom_range(1025, 2047));
    cmd = ($urandom_range(0, 3) == 0) ? CMD_WRITE : CMD_READ;
    span = (ldw == 11'd0 || ldw > LEN_MAX_DWORDS) ? 4096 : int'(ldw) * 4;
    r = $urandom_range(0, 99);
    if (cmd == CMD_WRITE) begin
      bc = (r < 80) ? 13'($urandom_range(1, 256)) : 13'($urandom_range(0, 8191));
    end else if (r < 70) begin
      span = span - int'(addr[1:0]) - int'($urandom_range(0, 3));
      bc = 13'((span < 1) ? 1 : span);
    end else if (r < 85) begin
      bc = 13'($urandom_range(1, span));
    end else begin
      bc = 13'($urandom_range(0, 8191));
    end
    send_request(cmd, addr, ldw, bc, 8'($urandom), 16'($urandom));
  endtask

  task automatic test_random_traffic();
    set_window(64'h0, 32'h0001_0000, 16'h1234);
    for (int i = 0; i < 50; i++) send_random_request();
    drain();
    // first stretch runs back to back on both sides
    set_window(64'h8000_0000_0000_0000 | 64'($urandom), 32'hFFFF_FFFF, 16'($urandom));
    idle_off = 1'b1;
    for (int i = 0; i < 20; i++) send_random_request();
    idle_off = 1'b0;
    for (int i = 0; i < 30; i++) send_random_request();
    drain();
    set_window({$urandom, $urandom}, $urandom, 16'($urandom));
    for (int i = 0; i < 40; i++) send_random_request();
    drain();
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_READ;
    cfg_we     = 1'b0;
    cfg_index  = REG_WINDOW_BASE;
    cfg_data   = '0;
    idle_off   = 1'b0;
    mismatches = 0;
    n_reads    = 0;
    n_writes   = 0;
    n_aborts   = 0;
    n_headers  = 0;
    n_settings = 1;
    // reset values of the registers
    win_base = 64'h0;
    win_size = 32'h1000_0000;
    cpl_id   = 16'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_window();
    test_window_edges();
    test_random_traffic();

    $display("covered %0d reads and %0d writes (%0d out of window) over %0d window settings",
             n_reads, n_writes, n_aborts, n_settings);
    $display("checked %0d result transfers field by field", n_headers);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[pcie_completion_splitter_top.f]
rtl/pcs_pkg.sv
rtl/pcs_front.sv
rtl/pcs_queue.sv
rtl/pcs_back.sv
rtl/pcie_completion_splitter_top.sv
tb/tb.sv
